// ----- rtl/bem_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the battery event monitor.
// No dependencies; every other file imports this package.

package bem_pkg;

   localparam int unsigned LevelWidth    = 7;
   localparam int unsigned TempWidth     = 12;
   localparam int unsigned VoltWidth     = 16;
   localparam int unsigned TimeWidth     = 40;
   localparam int unsigned CsrIndexWidth = 3;

   typedef logic [LevelWidth-1:0]       level_type;
   typedef logic signed [TempWidth-1:0] temp_type;
   typedef logic [VoltWidth-1:0]        volt_type;
   typedef logic [TimeWidth-1:0]        time_type;
   typedef logic [CsrIndexWidth-1:0]    csr_index_type;

   // plug kinds; PLUG_INIT marks that no sample has been recorded yet
   localparam logic [1:0] PLUG_NONE = 2'd0;
   localparam logic [1:0] PLUG_AC   = 2'd1;
   localparam logic [1:0] PLUG_USB  = 2'd2;
   localparam logic [1:0] PLUG_INIT = 2'd3;

   localparam logic [2:0] STATUS_UNKNOWN     = 3'd0;
   localparam logic [2:0] STATUS_CHARGING    = 3'd1;
   localparam logic [2:0] STATUS_DISCHARGING = 3'd2;
   localparam logic [2:0] STATUS_FULL        = 3'd4;

   localparam logic [1:0] ICON_CHARGING = 2'd0;
   localparam logic [1:0] ICON_NORMAL   = 2'd1;
   localparam logic [1:0] ICON_UNKNOWN  = 2'd2;

   // configuration register indexes
   localparam csr_index_type CSR_LOW_WARNING    = 3'd0;
   localparam csr_index_type CSR_LOW_RELEASE    = 3'd1;
   localparam csr_index_type CSR_CRITICAL       = 3'd2;
   localparam csr_index_type CSR_OVER_TEMP      = 3'd3;
   localparam csr_index_type CSR_OUTLIER_ENABLE = 3'd4;
   localparam csr_index_type CSR_OUTLIER_DROP   = 3'd5;
   localparam csr_index_type CSR_DURATION_LIMIT = 3'd6;

   localparam level_type LowWarningReset  = 7'd15;
   localparam level_type LowReleaseReset  = 7'd20;
   localparam level_type CriticalReset    = 7'd4;
   localparam temp_type  OverTempReset    = 12'sd680;

   typedef struct packed {
      logic          ac_online;
      logic          usb_online;
      logic          battery_present;
      level_type     charge_level;
      volt_type      voltage_mv;
      temp_type      temperature;
      logic [2:0]    charge_status;
      logic [2:0]    health;
      logic          system_ready;
      time_type      now_ms;
   } bem_req_type;

   typedef struct packed {
      logic          any_change;
      logic [1:0]    plug_kind;
      logic          is_powered;
      logic          connected_event;
      logic          disconnected_event;
      logic          low_event;
      logic          okay_event;
      logic          shutdown_request;
      logic          outlier_flag;
      time_type      discharge_time;
      logic [1:0]    icon_kind;
   } bem_rsp_type;

   typedef struct packed {
      csr_index_type reg_index;
      time_type      wdata;
   } bem_csr_type;

endpackage

// ----- rtl/bem_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the battery event monitor:
// sample input, result output and register write. Depends on bem_pkg.

interface bem_req_if import bem_pkg::*; ();
   logic        valid;
   logic        ready;
   bem_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bem_rsp_if import bem_pkg::*; ();
   logic        valid;
   logic        ready;
   bem_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bem_csr_if import bem_pkg::*; ();
   logic        valid;
   logic        ready;
   bem_csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/battery_event_monitor.sv -----
`timescale 1ns / 1ps
// Battery event monitor top level: sample register, event logic, result register.
// Depends on bem_pkg and the channel interfaces in bem_if.sv.
//
//   channel  dir  beat
//   req_ch   in   one battery sample with timestamp
//   rsp_ch   out  one result per sample (events, shutdown, discharge time)
//   csr_ch   in   register index and write data, always ready
//
// One sample per cycle unless the result side stalls; a taken sample moves from the
// sample register into the result register. The event logic runs between the sample
// register and the result register, and the tracking state is updated as a
// sample moves into the result register. A stalled result holds both registers;
// the sample register still refills in the cycle the result leaves. Synchronous
// reset clears both valid flags and restores configuration and tracking state.

module battery_event_monitor import bem_pkg::*; (
   input logic       clock,
   input logic       reset,
   bem_req_if.sink   req_ch,
   bem_rsp_if.source rsp_ch,
   bem_csr_if.sink   csr_ch
);

   // configuration
   level_type low_warning_ff;
   level_type low_release_ff;
   level_type critical_ff;
   temp_type  over_temp_ff;
   logic      outlier_enable_ff;
   level_type outlier_drop_ff;
   time_type  duration_limit_ff;

   // tracking state
   logic [2:0] prev_status_ff;
   logic [2:0] prev_health_ff;
   logic       prev_present_ff;
   level_type  prev_level_ff;
   logic [1:0] prev_plug_ff;
   volt_type   prev_voltage_ff;
   temp_type   prev_temp_ff;
   logic       prev_critical_ff;
   logic       low_sent_ff;
   time_type   start_ms_ff;
   level_type  start_level_ff;

   // pipeline
   logic        smp_valid_ff;
   bem_req_type smp_ff;
   logic        rsp_valid_ff;
   bem_rsp_type rsp_ff;
   bem_rsp_type rsp_in;

   logic advance;
   logic take;

   logic [1:0] plug;
   logic       powered;
   logic       critical;
   logic       hot;
   logic       change;
   logic       plug_moved;
   logic       start_new;
   logic       end_discharge;
   logic       crit_edge;
   logic       log_dur;
   logic       send_low;
   logic       okay;
   logic       drop_ok;
   time_type   eff_start;
   time_type   dur;
   level_type  eff_level;
   logic [LevelWidth:0] drop;

   assign advance      = smp_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !smp_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   always_comb begin
      plug = smp_ff.ac_online ? PLUG_AC : (smp_ff.usb_online ? PLUG_USB : PLUG_NONE);
      powered  = smp_ff.ac_online || smp_ff.usb_online ||
                 (smp_ff.charge_status == STATUS_UNKNOWN);
      critical = smp_ff.charge_level <= critical_ff;
      hot      = smp_ff.temperature > over_temp_ff;

      change = (smp_ff.charge_status != prev_status_ff) ||
               (smp_ff.health != prev_health_ff) ||
               (smp_ff.battery_present != prev_present_ff) ||
               (smp_ff.charge_level != prev_level_ff) ||
               (plug != prev_plug_ff) ||
               (smp_ff.voltage_mv != prev_voltage_ff) ||
               (smp_ff.temperature != prev_temp_ff);

      plug_moved    = change && (plug != prev_plug_ff);
      start_new     = plug_moved && (prev_plug_ff != PLUG_NONE) && (plug == PLUG_NONE);
      end_discharge = plug_moved && (prev_plug_ff == PLUG_NONE) &&
                      (start_ms_ff != '0) && (start_level_ff != smp_ff.charge_level);
      crit_edge     = change && critical && !prev_critical_ff && (plug == PLUG_NONE);
      log_dur       = end_discharge || crit_edge;

      // a discharge that starts on this sample is measured from now
      eff_start = start_new ? smp_ff.now_ms : start_ms_ff;
      eff_level = start_new ? smp_ff.charge_level : start_level_ff;
      dur       = log_dur ? (smp_ff.now_ms - eff_start) : '0;

      drop    = {1'b0, eff_level} - {1'b0, smp_ff.charge_level};
      drop_ok = !drop[LevelWidth] && (drop[LevelWidth-1:0] >= outlier_drop_ff);

      send_low = change && (plug == PLUG_NONE) &&
                 (smp_ff.charge_status != STATUS_UNKNOWN) &&
                 (smp_ff.charge_level <= low_warning_ff) &&
                 ((prev_plug_ff != PLUG_NONE) || (prev_level_ff > low_warning_ff));
      okay     = change && !send_low && low_sent_ff && (prev_level_ff >= low_release_ff);

      rsp_in.any_change         = change;
      rsp_in.plug_kind          = plug;
      rsp_in.is_powered         = powered;
      rsp_in.connected_event    = change && (plug != PLUG_NONE) && (prev_plug_ff == PLUG_NONE);
      rsp_in.disconnected_event = change && (plug == PLUG_NONE) && (prev_plug_ff != PLUG_NONE);
      rsp_in.low_event          = send_low;
      rsp_in.okay_event         = okay;
      rsp_in.shutdown_request   = smp_ff.system_ready &&
                                  (((smp_ff.charge_level == '0) && !powered) || hot);
      rsp_in.outlier_flag       = log_dur && (dur != '0) && outlier_enable_ff &&
                                  (dur <= duration_limit_ff) && drop_ok;
      rsp_in.discharge_time     = dur;
      if (smp_ff.charge_status == STATUS_CHARGING) begin
         rsp_in.icon_kind = ICON_CHARGING;
      end else if (smp_ff.charge_status inside {[STATUS_DISCHARGING:STATUS_FULL]}) begin
         rsp_in.icon_kind = ICON_NORMAL;
      end else begin
         rsp_in.icon_kind = ICON_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_warning_ff    <= LowWarningReset;
         low_release_ff    <= LowReleaseReset;
         critical_ff       <= CriticalReset;
         over_temp_ff      <= OverTempReset;
         outlier_enable_ff <= 1'b0;
         outlier_drop_ff   <= '0;
         duration_limit_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.data.reg_index)
            CSR_LOW_WARNING:    low_warning_ff    <= csr_ch.data.wdata[LevelWidth-1:0];
            CSR_LOW_RELEASE:    low_release_ff    <= csr_ch.data.wdata[LevelWidth-1:0];
            CSR_CRITICAL:       critical_ff       <= csr_ch.data.wdata[LevelWidth-1:0];
            CSR_OVER_TEMP:      over_temp_ff      <= $signed(csr_ch.data.wdata[TempWidth-1:0]);
            CSR_OUTLIER_ENABLE: outlier_enable_ff <= csr_ch.data.wdata[0];
            CSR_OUTLIER_DROP:   outlier_drop_ff   <= csr_ch.data.wdata[LevelWidth-1:0];
            CSR_DURATION_LIMIT: duration_limit_ff <= csr_ch.data.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            smp_valid_ff <= 1'b1;
         end else if (advance) begin
            smp_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         smp_ff <= req_ch.data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_status_ff   <= STATUS_UNKNOWN;
         prev_health_ff   <= '0;
         prev_present_ff  <= 1'b0;
         prev_level_ff    <= '0;
         prev_plug_ff     <= PLUG_INIT;
         prev_voltage_ff  <= '0;
         prev_temp_ff     <= '0;
         prev_critical_ff <= 1'b0;
         low_sent_ff      <= 1'b0;
         start_ms_ff      <= '0;
         start_level_ff   <= '0;
      end else if (advance && change) begin
         prev_status_ff   <= smp_ff.charge_status;
         prev_health_ff   <= smp_ff.health;
         prev_present_ff  <= smp_ff.battery_present;
         prev_level_ff    <= smp_ff.charge_level;
         prev_plug_ff     <= plug;
         prev_voltage_ff  <= smp_ff.voltage_mv;
         prev_temp_ff     <= smp_ff.temperature;
         prev_critical_ff <= critical;
         if (send_low) begin
            low_sent_ff <= 1'b1;
         end else if (okay) begin
            low_sent_ff <= 1'b0;
         end
         // close a logged discharge, or open one on unplug
         if (end_discharge) begin
            start_ms_ff <= '0;
         end else if (start_new) begin
            start_ms_ff    <= smp_ff.now_ms;
            start_level_ff <= smp_ff.charge_level;
         end
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for battery_event_monitor: directed and random samples under
// several register settings, results checked against an in-bench predictor.
// Depends on bem_pkg, the channel interfaces in bem_if.sv and the RTL top level.

module tb;
   import bem_pkg::*;

   localparam csr_index_type CSR_SPARE        = 3'd7;  // unmapped, writes are dropped
   localparam logic [2:0] STATUS_NOT_CHARGING = 3'd3;
   localparam logic [2:0] HEALTH_GOOD         = 3'd1;
   localparam int unsigned IdlePercent = 14;
   localparam int unsigned HoldCycles  = 60;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned PhaseItems  = 60;
   localparam time_type TimeMax = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   bem_req_type req_data  = '0;
   logic        rsp_ready = 1'b0;
   logic        csr_valid = 1'b0;
   bem_csr_type csr_data  = '0;

   bem_req_if req_ch ();
   bem_rsp_if rsp_ch ();
   bem_csr_if csr_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.data  = req_data;
   assign rsp_ch.ready = rsp_ready;
   assign csr_ch.valid = csr_valid;
   assign csr_ch.data  = csr_data;

   battery_event_monitor u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   // register copies
   level_type cfg_low_warning, cfg_low_release, cfg_critical, cfg_outlier_drop;
   temp_type  cfg_over_temp;
   logic      cfg_outlier_enable;
   time_type  cfg_duration_limit;

   // last recorded sample and discharge tracking
   logic [2:0] seen_status, seen_health;
   logic       seen_present, seen_critical, low_reported;
   level_type  seen_level, discharge_level;
   logic [1:0] seen_plug;
   volt_type   seen_voltage;
   temp_type   seen_temp;
   time_type   discharge_start;

   bem_req_type samples_to_send[$];
   bem_rsp_type pending_outcomes[$];
   int unsigned samples_queued = 0;
   int unsigned results_seen   = 0;
   int unsigned csr_writes     = 0;
   int unsigned errors         = 0;
   int unsigned cycle_count    = 0;
   int unsigned hold_requests  = 0;
   int unsigned holds_served   = 0;
   int unsigned hold_left      = 0;
   logic        req_took       = 1'b0;
   bit          steady         = 1'b0;

   // random walk of a plausible battery
   level_type   walk_level = 7'd60;
   logic [1:0]  walk_plug  = PLUG_NONE;
   temp_type    walk_temp  = 12'sd300;
   time_type    walk_ms    = 40'd5000;
   bem_req_type walk_last  = '0;

   function automatic bem_rsp_type battery_outcome(input bem_req_type s);
      bem_rsp_type r;
      logic        critical, hot, logged, send_low;
      int          level_drop;
      r = '0;
      r.plug_kind  = s.ac_online ? PLUG_AC : (s.usb_online ? PLUG_USB : PLUG_NONE);
      r.is_powered = s.ac_online || s.usb_online || s.charge_status == STATUS_UNKNOWN;
      critical     = s.charge_level <= cfg_critical;
      hot          = $signed(s.temperature) > $signed(cfg_over_temp);
      r.shutdown_request = s.system_ready &&
                           ((s.charge_level == 0 && !r.is_powered) || hot);
      if (s.charge_status == STATUS_CHARGING) begin
         r.icon_kind = ICON_CHARGING;
      end else if (s.charge_status >= STATUS_DISCHARGING && s.charge_status <= STATUS_FULL) begin
         r.icon_kind = ICON_NORMAL;
      end else begin
         r.icon_kind = ICON_UNKNOWN;
      end
      r.any_change = s.charge_status != seen_status || s.health != seen_health ||
                     s.battery_present != seen_present || s.charge_level != seen_level ||
                     r.plug_kind != seen_plug || s.voltage_mv != seen_voltage ||
                     s.temperature != seen_temp;
      if (r.any_change) begin
         logged = 1'b0;
         if (r.plug_kind != seen_plug) begin
            if (seen_plug == PLUG_NONE) begin
               if (discharge_start != 0 && discharge_level != s.charge_level) begin
                  r.discharge_time = s.now_ms - discharge_start;
                  logged = 1'b1;
                  discharge_start = '0;
               end
            end else if (r.plug_kind == PLUG_NONE) begin
               discharge_start = s.now_ms;
               discharge_level = s.charge_level;
            end
         end
         if (critical && !seen_critical && r.plug_kind == PLUG_NONE) begin
            r.discharge_time = s.now_ms - discharge_start;
            logged = 1'b1;
         end
         // the no-sample-yet plug code counts as plugged
         send_low = r.plug_kind == PLUG_NONE && s.charge_status != STATUS_UNKNOWN &&
                    s.charge_level <= cfg_low_warning &&
                    (seen_plug != PLUG_NONE || seen_level > cfg_low_warning);
         if (r.plug_kind != PLUG_NONE && seen_plug == PLUG_NONE) begin
            r.connected_event = 1'b1;
         end else if (r.plug_kind == PLUG_NONE && seen_plug != PLUG_NONE) begin
            r.disconnected_event = 1'b1;
         end
         if (send_low) begin
            low_reported = 1'b1;
            r.low_event  = 1'b1;
         end else if (low_reported && seen_level >= cfg_low_release) begin
            low_reported = 1'b0;
            r.okay_event = 1'b1;
         end
         level_drop = int'(discharge_level) - int'(s.charge_level);
         if (logged && r.discharge_time != 0 && cfg_outlier_enable &&
             r.discharge_time <= cfg_duration_limit && level_drop >= int'(cfg_outlier_drop)) begin
            r.outlier_flag = 1'b1;
         end
         seen_status   = s.charge_status;
         seen_health   = s.health;
         seen_present  = s.battery_present;
         seen_level    = s.charge_level;
         seen_plug     = r.plug_kind;
         seen_voltage  = s.voltage_mv;
         seen_temp     = s.temperature;
         seen_critical = critical;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input time_type want_v, input time_type got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         errors++;
      end
   endtask

   // acceptance, prediction and result check
   always @(posedge clock) begin
      bem_rsp_type want;
      bem_rsp_type got;
      if (reset) begin
         req_took           = 1'b0;
         cfg_low_warning    = LowWarningReset;
         cfg_low_release    = LowReleaseReset;
         cfg_critical       = CriticalReset;
         cfg_over_temp      = OverTempReset;
         cfg_outlier_enable = 1'b0;
         cfg_outlier_drop   = '0;
         cfg_duration_limit = '0;
         seen_status        = '0;
         seen_health        = '0;
         seen_present       = 1'b0;
         seen_level         = '0;
         seen_plug          = PLUG_INIT;
         seen_voltage       = '0;
         seen_temp          = '0;
         seen_critical      = 1'b0;
         low_reported       = 1'b0;
         discharge_start    = '0;
         discharge_level    = '0;
      end else begin
         req_took = req_valid && req_ch.ready;
         if (csr_valid && csr_ch.ready) begin
            case (csr_data.reg_index)
               CSR_LOW_WARNING:    cfg_low_warning    = csr_data.wdata[LevelWidth-1:0];
               CSR_LOW_RELEASE:    cfg_low_release    = csr_data.wdata[LevelWidth-1:0];
               CSR_CRITICAL:       cfg_critical       = csr_data.wdata[LevelWidth-1:0];
               CSR_OVER_TEMP:      cfg_over_temp      = csr_data.wdata[TempWidth-1:0];
               CSR_OUTLIER_ENABLE: cfg_outlier_enable = csr_data.wdata[0];
               CSR_OUTLIER_DROP:   cfg_outlier_drop   = csr_data.wdata[LevelWidth-1:0];
               CSR_DURATION_LIMIT: cfg_duration_limit = csr_data.wdata;
               default: ;
            endcase
            csr_writes++;
         end
         if (req_took) begin
            pending_outcomes.push_back(battery_outcome(req_data));
         end
         if (rsp_ch.valid && rsp_ready) begin
            results_seen++;
            got = rsp_ch.data;
            if (pending_outcomes.size() == 0) begin
               $error("result beat with no sample outstanding");
               errors++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("any_change", want.any_change, got.any_change);
               check_field("plug_kind", want.plug_kind, got.plug_kind);
               check_field("is_powered", want.is_powered, got.is_powered);
               check_field("connected_event", want.connected_event, got.connected_event);
               check_field("disconnected_event", want.disconnected_event,
                           got.disconnected_event);
               check_field("low_event", want.low_event, got.low_event);
               check_field("okay_event", want.okay_event, got.okay_event);
               check_field("shutdown_request", want.shutdown_request, got.shutdown_request);
               check_field("outlier_flag", want.outlier_flag, got.outlier_flag);
               check_field("discharge_time", want.discharge_time, got.discharge_time);
               check_field("icon_kind", want.icon_kind, got.icon_kind);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("** battery_event_monitor: FAILED **");
         $finish;
      end
   end

   // sample driver: hold the beat until taken, then advance or idle
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= IdlePercent)) begin
            req_data  <= samples_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HoldCycles;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || $urandom_range(99) >= IdlePercent;
      end
   end

   task automatic send_sample(input bem_req_type s);
      samples_to_send.push_back(s);
      samples_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (results_seen < samples_queued);
   endtask

   task automatic write_reg(input csr_index_type idx, input time_type value);
      int unsigned seen;
      seen = csr_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= '{reg_index: idx, wdata: value};
      do @(negedge clock);
      while (csr_writes == seen);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input level_type warn_lvl, input level_type rel_lvl,
                            input level_type crit_lvl, input temp_type temp_lim,
                            input logic outlier_on, input level_type drop_lvl,
                            input time_type dur_lim);
      write_reg(CSR_LOW_WARNING, time_type'(warn_lvl));
      write_reg(CSR_LOW_RELEASE, time_type'(rel_lvl));
      write_reg(CSR_CRITICAL, time_type'(crit_lvl));
      write_reg(CSR_OVER_TEMP, {28'd0, temp_lim});
      write_reg(CSR_OUTLIER_ENABLE, time_type'(outlier_on));
      write_reg(CSR_OUTLIER_DROP, time_type'(drop_lvl));
      write_reg(CSR_DURATION_LIMIT, dur_lim);
   endtask

   function automatic bem_req_type sample_of(input logic ac, input logic usb,
                                             input logic present, input int lvl,
                                             input int volt, input int temp,
                                             input logic [2:0] stat, input logic [2:0] hlth,
                                             input logic rdy, input time_type now);
      bem_req_type s;
      s.ac_online       = ac;
      s.usb_online      = usb;
      s.battery_present = present;
      s.charge_level    = level_type'(lvl);
      s.voltage_mv      = volt_type'(volt);
      s.temperature     = temp_type'(temp);
      s.charge_status   = stat;
      s.health          = hlth;
      s.system_ready    = rdy;
      s.now_ms          = now;
      return s;
   endfunction

   // mostly a plausible charge/discharge walk; noise draws every field at full width
   function automatic bem_req_type next_sample(input bit noisy);
      bem_req_type s;
      int          t;
      if (noisy) begin
         s = sample_of($urandom_range(1), $urandom_range(1), $urandom_range(1),
                       $urandom_range(127), $urandom_range(65535), $urandom_range(4095),
                       $urandom_range(7), $urandom_range(7), $urandom_range(1),
                       time_type'({$urandom(), $urandom()}));
      end else if ($urandom_range(7) == 0) begin
         // repeat the last reading: nothing tracked changes
         s = walk_last;
         walk_ms += $urandom_range(1, 4000);
         s.now_ms = walk_ms;
         s.system_ready = $urandom_range(9) != 0;
      end else begin
         if ($urandom_range(9) == 0) walk_plug = $urandom_range(2);
         walk_ms += ($urandom_range(15) == 0) ? $urandom_range(1, 2000000)
                                              : $urandom_range(1, 4000);
         if ($urandom_range(19) == 0) begin
            t = $urandom_range(30);
         end else begin
            t = int'(walk_level) + (walk_plug == PLUG_NONE ? -int'($urandom_range(3))
                                                          : int'($urandom_range(3)));
         end
         walk_level = level_type'(t < 0 ? 0 : (t > 100 ? 100 : t));
         t = ($urandom_range(24) == 0) ? $urandom_range(600, 760)
                                       : int'(walk_temp) + int'($urandom_range(40)) - 20;
         walk_temp = temp_type'(t < -1000 ? -1000 : (t > 1500 ? 1500 : t));
         s = sample_of(walk_plug == PLUG_AC,
                       walk_plug == PLUG_USB || (walk_plug == PLUG_AC && $urandom_range(1)),
                       $urandom_range(49) != 0, walk_level, 3400 + 7 * int'(walk_level),
                       walk_temp, STATUS_DISCHARGING, HEALTH_GOOD,
                       $urandom_range(9) != 0, walk_ms);
         if (walk_plug != PLUG_NONE) begin
            s.charge_status = (walk_level == 100) ? STATUS_FULL : STATUS_CHARGING;
         end
         if ($urandom_range(9) == 0) s.charge_status = $urandom_range(7);
         if ($urandom_range(14) == 0) s.health = $urandom_range(7);
      end
      walk_last = s;
      return s;
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed samples under the reset settings
      send_sample(sample_of(0, 0, 1, 10, 3700, 250, STATUS_DISCHARGING, HEALTH_GOOD, 1, 1000));
      send_sample(sample_of(0, 0, 1, 10, 3700, 250, STATUS_DISCHARGING, HEALTH_GOOD, 0, 1500));
      send_sample(sample_of(1, 0, 1, 12, 3710, 250, STATUS_CHARGING, HEALTH_GOOD, 1, 61000));
      send_sample(sample_of(1, 1, 1, 13, 3720, 250, STATUS_CHARGING, HEALTH_GOOD, 1, 62000));
      send_sample(sample_of(0, 1, 1, 25, 3730, 250, STATUS_CHARGING, HEALTH_GOOD, 1, 63000));
      send_sample(sample_of(0, 1, 1, 26, 3740, 250, STATUS_CHARGING, HEALTH_GOOD, 1, 64000));
      send_sample(sample_of(0, 0, 1, 30, 3750, 250, STATUS_DISCHARGING, HEALTH_GOOD, 1,
                            TimeMax - 100));
      // time runs backwards across the critical crossing, so the duration wraps
      send_sample(sample_of(0, 0, 1, 4, 3500, 250, STATUS_DISCHARGING, HEALTH_GOOD, 1, 500));
      send_sample(sample_of(0, 0, 1, 0, 3300, 250, STATUS_DISCHARGING, HEALTH_GOOD, 1, 900));
      send_sample(sample_of(0, 0, 1, 0, 0, 250, STATUS_UNKNOWN, HEALTH_GOOD, 1, 1200));
      send_sample(sample_of(1, 0, 1, 50, 65535, 681, STATUS_CHARGING, HEALTH_GOOD, 1, 2000));
      send_sample(sample_of(1, 0, 1, 50, 3800, 680, STATUS_NOT_CHARGING, HEALTH_GOOD, 1, 3000));
      send_sample(sample_of(1, 0, 1, 50, 3800, -2048, STATUS_FULL, 0, 1, 4000));
      send_sample(sample_of(1, 0, 0, 50, 3800, 2047, 5, 7, 1, 5000));
      send_sample(sample_of(1, 0, 1, 50, 3800, -1000, 6, 5, 1, 6000));
      send_sample(sample_of(1, 0, 1, 100, 3800, 1500, 7, 2, 1, 7000));
      send_sample(sample_of(1, 0, 1, 127, 3800, 1500, 7, 2, 0, 8000));
      send_sample(sample_of(0, 0, 1, 127, 3800, 300, STATUS_DISCHARGING, 3, 1, 0));
      send_sample(sample_of(0, 1, 1, 120, 3800, 300, STATUS_CHARGING, 4, 1, 9000));
      send_sample(sample_of(0, 0, 1, 10, 3600, 300, STATUS_UNKNOWN, HEALTH_GOOD, 1, 10000));
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               configure(LowWarningReset, LowReleaseReset, CriticalReset, OverTempReset,
                         1'b0, '0, '0);
               write_reg(CSR_SPARE, TimeMax);
            end
            1: configure(0, 0, 0, -1000, 1'b1, 0, '0);
            2: configure(100, 100, 100, 1500, 1'b1, 100, TimeMax);
            3: configure(127, 127, 127, 2047, 1'b1, 127, TimeMax);
            4: configure(20, 25, 5, -2048, 1'b1, 0, 40'd2000000);
            default: begin
               configure($urandom_range(127), $urandom_range(127), $urandom_range(30),
                         $urandom_range(4095), $urandom_range(1), $urandom_range(20),
                         $urandom_range(1) ? time_type'({$urandom(), $urandom()})
                                           : time_type'($urandom_range(300000)));
            end
         endcase
         steady = (p == 4);
         // stall the result side long enough for the block to back up
         if (p == 2 || p == 5) hold_requests++;
         repeat (PhaseItems) send_sample(next_sample($urandom_range(99) < 25));
         wait_idle();
      end

      steady = 1'b0;
      repeat (DrainCycles) @(negedge clock);
      if (errors == 0 && pending_outcomes.size() == 0) begin
         $display("** battery_event_monitor: PASSED **");
      end else begin
         $display("** battery_event_monitor: FAILED **");
      end
      $finish;
   end

endmodule
